// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and controller/datapath link types for the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int RAM_DEPTH = 2 * BUF_DEPTH;
    localparam int CMP_W     = 6;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd2;

    localparam logic [7:0] HEADER_RST = 8'h55;
    localparam logic [3:0] MIN_RST    = 4'd3;
    localparam logic [3:0] MAX_RST    = 4'd7;

    localparam logic [0:0] REQ_BYTE = 1'b0;
    localparam logic [0:0] REQ_POLL = 1'b1;

    typedef struct packed {
        logic take_byte;
        logic write_hdr1;
        logic start_poll;
        logic empty_poll;
        logic load_out;
        logic advance;
    } sfr_cmd_t;

    typedef struct packed {
        logic entering;
        logic pending;
        logic last;
    } sfr_status_t;

endpackage

// ===== rtl/sfr_ram.sv =====
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sfr_datapath.sv =====
// ----------------------------------------------------------------------------
// sfr_datapath
// Frame state, configuration registers, double-banked frame store and
// result registers.
// ----------------------------------------------------------------------------
module sfr_datapath
    import sfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfr_cmd_t             cmd,
    output sfr_status_t          status,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [0:0]           req_type,
    input  logic [7:0]           rx_byte,
    output logic                 frame_ready,
    output logic [7:0]           frame_byte,
    output logic [3:0]           byte_index,
    output logic                 last
);

    logic [7:0]       header_reg, header_next;
    logic [3:0]       min_reg, min_next;
    logic [3:0]       max_reg, max_next;
    logic             hc_reg, hc_next;
    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] bc_reg, bc_next;
    logic [3:0]       fl_reg, fl_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             pending_reg, pending_next;
    logic             wb_reg, wb_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             flag_reg, flag_next;
    logic [7:0]       byte_reg, byte_next;

    logic                         ram_we;
    logic [$clog2(RAM_DEPTH)-1:0] ram_waddr;
    logic [7:0]                   ram_wdata;
    logic [$clog2(RAM_DEPTH)-1:0] ram_raddr;
    logic [7:0]                   ram_rdata;

    logic [CNT_W-1:0] bc_inc;
    logic [CNT_W-1:0] held_last;
    logic [3:0]       fl_eff;
    logic             len_bad;
    logic             is_len_pos;

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // held frame lives in the bank not being written
    assign ram_raddr = {~wb_reg, idx_reg};

    assign bc_inc     = bc_reg + 1'b1;
    assign held_last  = held_reg - 1'b1;
    assign is_len_pos = (bc_reg == CNT_W'(3));
    assign len_bad    = (rx_byte < {4'b0, min_reg}) || (rx_byte > {4'b0, max_reg})
                        || (rx_byte > 8'(BUF_DEPTH - 3));
    assign fl_eff     = is_len_pos ? rx_byte[3:0] : fl_reg;

    assign status.entering = !in_frame_reg && hc_reg && (rx_byte == header_reg)
                             && (req_type == REQ_BYTE);
    assign status.pending  = pending_reg;
    assign status.last     = !flag_reg || (idx_reg == held_last[IDX_W-1:0]);

    assign frame_ready = flag_reg;
    assign frame_byte  = byte_reg;
    assign byte_index  = 4'(idx_reg);
    assign last        = status.last;

    always_comb
    begin
        header_next   = header_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        hc_next       = hc_reg;
        in_frame_next = in_frame_reg;
        bc_next       = bc_reg;
        fl_next       = fl_reg;
        held_next     = held_reg;
        pending_next  = pending_reg;
        wb_next       = wb_reg;
        idx_next      = idx_reg;
        flag_next     = flag_reg;
        byte_next     = byte_reg;
        ram_we        = 1'b0;
        ram_waddr     = {wb_reg, IDX_W'(0)};
        ram_wdata     = header_reg;

        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_HEADER: header_next = cfg_data;
                CFG_MIN:    min_next    = cfg_data[3:0];
                CFG_MAX:    max_next    = cfg_data[3:0];
                default:    ;
            endcase
        end

        if (cmd.take_byte)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == header_reg)
                begin
                    if (hc_reg)
                    begin
                        // second header byte: byte 0 now, byte 1 next cycle
                        hc_next       = 1'b0;
                        in_frame_next = 1'b1;
                        bc_next       = CNT_W'(2);
                        ram_we        = 1'b1;
                        ram_waddr     = {wb_reg, IDX_W'(0)};
                        ram_wdata     = header_reg;
                    end
                    else
                    begin
                        hc_next = 1'b1;
                    end
                end
                else
                begin
                    hc_next = 1'b0;
                    bc_next = '0;
                end
            end
            else if (bc_reg >= CNT_W'(BUF_DEPTH))
            begin
                in_frame_next = 1'b0;
            end
            else
            begin
                ram_we    = 1'b1;
                ram_waddr = {wb_reg, bc_reg[IDX_W-1:0]};
                ram_wdata = rx_byte;
                bc_next   = bc_inc;
                if (is_len_pos && len_bad)
                begin
                    fl_next       = 4'd3;
                    in_frame_next = 1'b0;
                end
                else
                begin
                    fl_next = fl_eff;
                    if ((CMP_W'(bc_inc) >= CMP_W'(4))
                        && (CMP_W'(bc_inc) >= CMP_W'(fl_eff) + CMP_W'(3)))
                    begin
                        in_frame_next = 1'b0;
                        if (!pending_reg)
                        begin
                            pending_next = 1'b1;
                            held_next    = bc_inc;
                            wb_next      = ~wb_reg;
                        end
                    end
                end
            end
        end

        if (cmd.write_hdr1)
        begin
            ram_we    = 1'b1;
            ram_waddr = {wb_reg, IDX_W'(1)};
            ram_wdata = header_reg;
        end

        if (cmd.start_poll)
        begin
            pending_next = 1'b0;
            idx_next     = '0;
            flag_next    = 1'b1;
        end

        if (cmd.empty_poll)
        begin
            idx_next  = '0;
            flag_next = 1'b0;
            byte_next = '0;
        end

        if (cmd.load_out)
        begin
            byte_next = ram_rdata;
        end

        if (cmd.advance)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= HEADER_RST;
            min_reg      <= MIN_RST;
            max_reg      <= MAX_RST;
            hc_reg       <= 1'b0;
            in_frame_reg <= 1'b0;
            bc_reg       <= '0;
            fl_reg       <= '0;
            held_reg     <= '0;
            pending_reg  <= 1'b0;
            wb_reg       <= 1'b0;
            idx_reg      <= '0;
            flag_reg     <= 1'b0;
        end
        else
        begin
            header_reg   <= header_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            hc_reg       <= hc_next;
            in_frame_reg <= in_frame_next;
            bc_reg       <= bc_next;
            fl_reg       <= fl_next;
            held_reg     <= held_next;
            pending_reg  <= pending_next;
            wb_reg       <= wb_next;
            idx_reg      <= idx_next;
            flag_reg     <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (held_reg >= CNT_W'(4)) && (held_reg <= CNT_W'(BUF_DEPTH)))
        else $error("held frame length out of range");

    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (bc_reg >= CNT_W'(2)) && (bc_reg < CNT_W'(BUF_DEPTH)))
        else $error("byte count out of range inside a frame");

    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_reg != $past(wb_reg)) |-> $rose(pending_reg))
        else $error("bank swapped without a newly held frame");

endmodule

// ===== rtl/sfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfr_ctrl
// Controller: input and output handshakes and the poll readout sequence.
// ----------------------------------------------------------------------------
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [0:0]  req_type,
    output logic        out_valid,
    input  logic        out_ready,
    input  sfr_status_t status,
    output sfr_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR1 = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_SHOW = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == REQ_BYTE)
                    begin
                        cmd.take_byte = 1'b1;
                        if (status.entering)
                        begin
                            state_next = S_HDR1;
                        end
                    end
                    else if (status.pending)
                    begin
                        cmd.start_poll = 1'b1;
                        state_next     = S_READ;
                    end
                    else
                    begin
                        cmd.empty_poll = 1'b1;
                        state_next     = S_SHOW;
                    end
                end
            end
            S_HDR1:
            begin
                cmd.write_hdr1 = 1'b1;
                state_next     = S_IDLE;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_out = 1'b1;
                state_next   = S_SHOW;
            end
            S_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_hdr1_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HDR1) |=> (state_reg == S_IDLE))
        else $error("second header write not followed by idle");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item taken while a result is shown");

    a_load_before_show: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_LOAD) ##1 (state_reg == S_SHOW))
        else $error("readout sequence broken");

endmodule

// ===== rtl/servo_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// servo_frame_receiver_core
// Deframer for packets opened by two equal header bytes, with a one-frame
// holding buffer that is emptied by a poll.
// ----------------------------------------------------------------------------
// in channel (in_valid/in_ready): req_type 0 carries a received byte in
//   rx_byte and gives no result; req_type 1 is a poll.
// out channel (out_valid/out_ready): a poll gives one result per held byte
//   (frame_ready 1, last on the final one), or one result with frame_ready 0
//   when no frame is pending.
// cfg channel (cfg_valid/cfg_ready): index 0 header byte, 1 min length,
//   2 max length; always ready, write only while the block is idle.
// a received byte is accepted in idle; the second header byte is followed by
//   a state that writes header byte 1, as the frame store has a single write port.
// a poll with a frame pending passes through the read, load and show states
//   for its first result and again for each further one once the previous is
//   taken (address, registered read, show); a poll with nothing pending gives
//   its single result in the cycle after acceptance.
// one item at a time: no item is accepted until the poll's last result is
//   taken; while out_ready is low the result holds and nothing moves.
// reset restores the register defaults and clears all frame state; the frame
//   store and the output byte register are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module servo_frame_receiver_core
    import sfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [0:0]           req_type,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 frame_ready,
    output logic [7:0]           frame_byte,
    output logic [3:0]           byte_index,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    sfr_cmd_t    cmd;
    sfr_status_t status;

    assign cfg_ready = 1'b1;

    sfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sfr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .rx_byte     (rx_byte),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .byte_index  (byte_index),
        .last        (last)
    );

endmodule

// ===== dv/tb_servo_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// tb_servo_frame_receiver_core
// Self-checking bench for the double-header frame receiver. A short table of
// directed items is followed by random traffic under several register
// settings and idling patterns. Every poll result is compared field by
// field against an in-bench deframer model or a fixed result from the table.
// ----------------------------------------------------------------------------
module tb_servo_frame_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int REPORT_LIMIT  = 40;
    localparam int ROW_COUNT     = 26;

    typedef struct packed {
        logic       frm_ready;
        logic [7:0] frm_byte;
        logic [3:0] frm_index;
        logic       frm_last;
    } frame_result_t;

    typedef struct packed {
        bit            fixed;
        logic [0:0]    rq;
        logic [7:0]    data;
        frame_result_t res;
    } stim_row_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam frame_result_t NO_FRAME = '{1'b0, 8'h00, 4'd0, 1'b1};

    localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{1'b1, REQ_POLL, 8'h00, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h55, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h55, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h00, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h03, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'hFF, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h00, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h55, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h55, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'hFF, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h03, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h80, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h01, NO_FRAME},
        '{1'b0, REQ_POLL, 8'hFF, NO_FRAME},
        '{1'b1, REQ_POLL, 8'h00, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h55, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h12, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h55, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h55, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h7F, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h08, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h55, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h55, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h01, NO_FRAME},
        '{1'b0, REQ_BYTE, 8'h02, NO_FRAME},
        '{1'b1, REQ_POLL, 8'h00, NO_FRAME}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [0:0]           req_type;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic                 frame_ready;
    logic [7:0]           frame_byte;
    logic [3:0]           byte_index;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // deframer model state and register mirror
    logic [7:0] hdr_value = HEADER_RST;
    logic [3:0] min_len   = MIN_RST;
    logic [3:0] max_len   = MAX_RST;
    bit         hdr_seen  = 1'b0;
    bit         framing   = 1'b0;
    logic [4:0] rx_pos    = '0;
    logic [3:0] frm_len   = '0;
    logic [7:0] rx_store   [BUF_DEPTH];
    logic [7:0] held_store [BUF_DEPTH];
    logic [4:0] held_len  = '0;
    bit         held_pend = 1'b0;

    frame_result_t frame_results_due [$];
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int            send_gap_pct   = 0;
    int            recv_stall_pct = 0;
    bit            hold_request   = 1'b0;
    idle_mode_t    idle_mode      = IDLE_NONE;

    servo_frame_receiver_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .byte_index  (byte_index),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic void absorb_rx_byte(input logic [7:0] b);
        int k;
        if (!framing)
        begin
            if (b == hdr_value)
            begin
                if (hdr_seen)
                begin
                    hdr_seen    = 1'b0;
                    framing     = 1'b1;
                    rx_pos      = 5'd1;
                    rx_store[0] = hdr_value;
                end
                else
                begin
                    hdr_seen = 1'b1;
                end
            end
            else
            begin
                hdr_seen = 1'b0;
                rx_pos   = '0;
            end
        end
        if (!framing)
            return;
        if (int'(rx_pos) >= BUF_DEPTH)
        begin
            framing = 1'b0;
            return;
        end
        rx_store[rx_pos[3:0]] = b;
        if (rx_pos == 5'd3)
        begin
            if (b < min_len || b > max_len || int'(b) + 3 > BUF_DEPTH)
            begin
                frm_len = 4'd3;
                framing = 1'b0;
                rx_pos  = rx_pos + 5'd1;
                return;
            end
            frm_len = b[3:0];
        end
        rx_pos = rx_pos + 5'd1;
        if (int'(rx_pos) >= 4 && int'(rx_pos) >= int'(frm_len) + 3)
        begin
            if (!held_pend)
            begin
                held_pend = 1'b1;
                held_len  = rx_pos;
                for (k = 0; k < int'(rx_pos); k++)
                    held_store[k] = rx_store[k];
            end
            framing = 1'b0;
        end
    endfunction

    function automatic void predict_poll(ref frame_result_t res [$]);
        int n;
        int k;
        if (!held_pend)
        begin
            res.push_back(NO_FRAME);
            return;
        end
        held_pend = 1'b0;
        n = int'(held_len);
        if (n > BUF_DEPTH)
            n = BUF_DEPTH;
        if (n == 0)
            n = 1;
        for (k = 0; k < n; k++)
            res.push_back('{1'b1, held_store[k], 4'(k), k == n - 1});
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
    endtask

    task automatic push_item(input logic [0:0] rq, input logic [7:0] b,
                             input bit fixed = 1'b0,
                             input frame_result_t fixed_res = NO_FRAME);
        frame_result_t due [$];
        in_valid <= 1'b1;
        req_type <= rq;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (rq == REQ_POLL)
            predict_poll(due);
        else
            absorb_rx_byte(b);
        if (fixed)
            due = '{fixed_res};
        foreach (due[k])
            frame_results_due.push_back(due[k]);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] hv, input logic [3:0] mn,
                              input logic [3:0] mx);
        logic [CFG_IDX_W-1:0] regs [3];
        logic [7:0]           vals [3];
        int                   k;
        regs = '{CFG_HEADER, CFG_MIN, CFG_MAX};
        // upper nibble of the length registers is don't care
        vals = '{hv, {4'($urandom_range(15)), mn}, {4'($urandom_range(15)), mx}};
        for (k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (regs[k])
                CFG_HEADER: hdr_value = vals[k];
                CFG_MIN:    min_len   = vals[k][3:0];
                CFG_MAX:    max_len   = vals[k][3:0];
                default:    ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t m);
        case (m)
            IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 64; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 64; end
            default:       begin send_gap_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    task automatic send_frame(output int n_sent);
        int ln;
        int total;
        int pick;
        int k;
        pick = $urandom_range(9);
        if (pick < 7 && min_len <= max_len)
            ln = $urandom_range(int'(max_len), int'(min_len));
        else if (pick < 9)
            ln = $urandom_range(15);
        else
            ln = $urandom_range(255);
        if (ln < int'(min_len) || ln > int'(max_len) || ln < 2)
            total = 4;
        else
            total = ln + 3;
        // cut some frames short
        if ($urandom_range(9) == 0)
            total = $urandom_range(total, 2);
        for (k = 0; k < total; k++)
        begin
            if (k < 2)
                push_item(REQ_BYTE, hdr_value);
            else if (k == 3)
                push_item(REQ_BYTE, 8'(ln));
            else
                push_item(REQ_BYTE, 8'($urandom));
        end
        n_sent = total;
    endtask

    task automatic random_traffic(input int n_items, output int n_done);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                send_frame(n);
                sent += n;
            end
            else if (pick < 78)
            begin
                push_item(REQ_POLL, 8'($urandom));
                sent++;
            end
            else if (pick < 90)
            begin
                push_item(REQ_BYTE, 8'($urandom));
                sent++;
            end
            else
            begin
                push_item(REQ_BYTE, hdr_value);
                push_item(REQ_BYTE, 8'($urandom));
                sent += 2;
            end
        end
        n_done = sent;
    endtask

    task automatic run_traffic(input int n_items);
        int done_items;
        int chunk;
        int got;
        done_items = 0;
        while (done_items < n_items)
        begin
            set_idling(idle_mode);
            idle_mode = idle_mode.next();
            chunk = (n_items - done_items < 10) ? n_items - done_items : 10;
            random_traffic(chunk, got);
            done_items += got;
            if ($urandom_range(3) == 0)
                wait_quiet();
        end
    endtask

    // long output hold-off while input keeps coming, then drain
    task automatic squeeze_output();
        int k;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        push_item(REQ_BYTE, hdr_value);
        push_item(REQ_BYTE, hdr_value);
        push_item(REQ_BYTE, 8'($urandom));
        push_item(REQ_BYTE, 8'(max_len));
        for (k = 4; k < int'(max_len) + 3; k++)
            push_item(REQ_BYTE, 8'($urandom));
        push_item(REQ_POLL, 8'h00);
        for (k = 0; k < 4; k++)
            push_item(REQ_BYTE, 8'($urandom));
        push_item(REQ_POLL, 8'h00);
        wait_quiet();
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_results_due.size() == 0)
            begin
                report_mismatch("result with none due", frame_byte, 8'h00);
            end
            else
            begin
                want = frame_results_due.pop_front();
                if (frame_ready !== want.frm_ready)
                    report_mismatch("frame_ready", 8'(frame_ready), 8'(want.frm_ready));
                if (frame_byte !== want.frm_byte)
                    report_mismatch("frame_byte", frame_byte, want.frm_byte);
                if (byte_index !== want.frm_index)
                    report_mismatch("byte_index", 8'(byte_index), 8'(want.frm_index));
                if (last !== want.frm_last)
                    report_mismatch("last", 8'(last), 8'(want.frm_last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int r;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = REQ_BYTE;
        rx_byte   = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = CFG_HEADER;
        cfg_data  = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < ROW_COUNT; r++)
            push_item(DIRECTED_ROWS[r].rq, DIRECTED_ROWS[r].data,
                      DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].res);
        run_traffic(40);

        wait_quiet();
        write_regs(8'h00, 4'd0, 4'd13);
        run_traffic(30);
        squeeze_output();
        run_traffic(20);

        wait_quiet();
        write_regs(8'hFF, 4'd13, 4'd13);
        run_traffic(30);

        // min above max rejects every length
        wait_quiet();
        write_regs(8'hA5, 4'd9, 4'd2);
        run_traffic(30);

        wait_quiet();
        write_regs(8'($urandom), 4'($urandom_range(13)), 4'($urandom_range(13)));
        run_traffic(30);

        wait_quiet();
        write_regs(HEADER_RST, 4'd1, 4'd4);
        run_traffic(30);

        wait_quiet();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sfr_pkg.sv
rtl/sfr_ram.sv
rtl/sfr_datapath.sv
rtl/sfr_ctrl.sv
rtl/servo_frame_receiver_core.sv
dv/tb_servo_frame_receiver_core.sv
